// ===== hdl/ivalloc_pkg.sv =====
// Shared types, codes and constants for the interrupt vector allocator.
`default_nettype none
package ivalloc_pkg;

	localparam logic [2:0] MODE_ALLOC_ONE   = 3'd0;
	localparam logic [2:0] MODE_ALLOC_BLOCK = 3'd1;
	localparam logic [2:0] MODE_FREE_RANGE  = 3'd2;
	localparam logic [2:0] MODE_FREE_ONE    = 3'd3;
	localparam logic [2:0] MODE_REGISTER    = 3'd4;
	localparam logic [2:0] MODE_UNREGISTER  = 3'd5;

	localparam logic [2:0] RC_OK          = 3'd0;
	localparam logic [2:0] RC_INVALID     = 3'd1;
	localparam logic [2:0] RC_NOT_ALLOC   = 3'd2;
	localparam logic [2:0] RC_ALREADY     = 3'd3;
	localparam logic [2:0] RC_NO_SPACE    = 3'd4;
	localparam logic [2:0] RC_EXHAUSTED   = 3'd5;
	localparam logic [2:0] RC_NOTHING_REG = 3'd6;

	localparam logic [1:0] VS_FREE  = 2'd0;
	localparam logic [1:0] VS_ALLOC = 2'd1;
	localparam logic [1:0] VS_REG   = 2'd2;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] vector;
		logic [7:0] count;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] granted_vector;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_FILL,
		S_RMW_RD,
		S_RMW_CHK,
		S_PUSH
	} state_t;

	typedef struct packed {
		logic       load;
		logic       scan_init;
		logic       target_init;
		logic       read;
		logic       step;
		logic       skip;
		logic       found;
		logic       write;
		logic [1:0] wdata;
		logic       result;
		logic [2:0] res_status;
		logic       res_grant;
		logic       push;
	} cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       blk_ok;
		logic       vec_ok;
		logic       rng_ok;
		logic       rng_empty;
		logic       in_table;
		logic [1:0] entry;
		logic       block_last;
		logic       fill_last;
		logic       out_free;
	} stat_t;

endpackage
`default_nettype wire

// ===== hdl/ivalloc_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ivalloc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ivalloc_dp.sv =====
// Datapath: request register, scan pointer, vector state store and result registers.
`default_nettype none
module ivalloc_dp #(
	parameter int NUM_VECTORS   = 256,
	parameter int FIRST_DYNAMIC = 32,
	parameter int MAX_BLOCK     = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ivalloc_pkg::req_t req,
	input  wire ivalloc_pkg::cmd_t cmd,
	output ivalloc_pkg::stat_t     stat,
	input  wire logic              rsp_stall,
	output logic                   rsp_valid,
	output ivalloc_pkg::rsp_t      rsp
);

	localparam int AW = $clog2(NUM_VECTORS);
	localparam int PW = AW + 1;
	localparam logic [8:0]    NV_W = 9'(NUM_VECTORS);
	localparam logic [8:0]    FD_W = 9'(FIRST_DYNAMIC);
	localparam logic [7:0]    MB_W = 8'(MAX_BLOCK);
	localparam logic [PW-1:0] FD_P = PW'(FIRST_DYNAMIC);
	localparam logic [PW:0]   NV_X = (PW + 1)'(NUM_VECTORS);

	ivalloc_pkg::req_t req_q;
	ivalloc_pkg::rsp_t rsp_q;
	ivalloc_pkg::rsp_t rsp_out_q;
	logic                   rsp_valid_q;
	logic [PW-1:0]          ptr_q;
	logic [PW-1:0]          mask_q;
	logic [PW-1:0]          cnt_q;
	logic [PW-1:0]          end_q;
	logic [PW-1:0]          base_q;
	logic [NUM_VECTORS-1:0] vld_q;
	logic                   rd_vld_s1;
	logic [1:0]             rd_data;

	logic [7:0]    eff_cnt;
	logic [8:0]    vec9;
	logic [8:0]    rng_sum;
	logic [PW-1:0] new_mask;
	logic [PW-1:0] start;
	logic [PW-1:0] scan_base;
	logic [PW-1:0] ptr_plus;
	logic [AW-1:0] addr;

	assign addr = ptr_q[AW-1:0];

	always_comb begin
		eff_cnt = (req_q.mode == ivalloc_pkg::MODE_ALLOC_ONE ||
			req_q.mode == ivalloc_pkg::MODE_FREE_ONE) ? 8'd1 : req_q.count;
		vec9      = {1'b0, req_q.vector};
		rng_sum   = vec9 + {1'b0, eff_cnt};
		new_mask  = PW'(eff_cnt) - PW'(1);
		// first base aligned to the block size at or above the dynamic range
		start     = (FD_P + new_mask) & ~new_mask;
		scan_base = ptr_q & ~mask_q;
		ptr_plus  = ptr_q + PW'(1);

		stat.mode       = req_q.mode;
		stat.blk_ok     = (req_q.count != 8'd0) && (req_q.count <= MB_W) &&
			((req_q.count & (req_q.count - 8'd1)) == 8'd0);
		stat.vec_ok     = (vec9 >= FD_W) && (vec9 < NV_W);
		stat.rng_ok     = (vec9 >= FD_W) && (rng_sum <= NV_W);
		stat.rng_empty  = (eff_cnt == 8'd0);
		stat.in_table   = ({1'b0, scan_base} + {1'b0, cnt_q}) <= NV_X;
		stat.entry      = rd_vld_s1 ? rd_data : ivalloc_pkg::VS_FREE;
		stat.block_last = ((ptr_plus & mask_q) == '0);
		stat.fill_last  = (ptr_plus == end_q);
		stat.out_free   = !rsp_valid_q || !rsp_stall;
	end

	ivalloc_ram #(
		.WIDTH(2),
		.DEPTH(NUM_VECTORS)
	) u_state_ram (
		.clk  (clk),
		.we   (cmd.write),
		.waddr(addr),
		.wdata(cmd.wdata),
		.re   (cmd.read),
		.raddr(addr),
		.rdata(rd_data)
	);

	// Entries never written read as free through the valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.write) begin
				vld_q[addr] <= 1'b1;
			end
			if (cmd.push) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.read) begin
			rd_vld_s1 <= vld_q[addr];
		end
		if (cmd.scan_init) begin
			ptr_q  <= start;
			mask_q <= new_mask;
			cnt_q  <= PW'(eff_cnt);
		end else if (cmd.target_init) begin
			ptr_q <= PW'(req_q.vector);
			end_q <= PW'(rng_sum);
		end else if (cmd.found) begin
			base_q <= scan_base;
			ptr_q  <= scan_base;
			end_q  <= scan_base + cnt_q;
		end else if (cmd.skip) begin
			// jump to the next aligned base
			ptr_q <= (ptr_q | mask_q) + PW'(1);
		end else if (cmd.step) begin
			ptr_q <= ptr_plus;
		end
		if (cmd.result) begin
			rsp_q.status         <= cmd.res_status;
			rsp_q.granted_vector <= cmd.res_grant ? 8'(base_q) : 8'd0;
		end
		if (cmd.push) begin
			rsp_out_q <= rsp_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_out_q;

endmodule
`default_nettype wire

// ===== hdl/ivalloc_ctrl.sv =====
// Controller state machine: sequences scans, fills and read-modify-writes.
`default_nettype none
module ivalloc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire ivalloc_pkg::stat_t stat,
	output ivalloc_pkg::cmd_t       cmd
);

	ivalloc_pkg::state_t state_q;
	ivalloc_pkg::state_t state_nxt;
	logic                is_alloc;
	logic [2:0]          fail_code;

	assign is_alloc  = stat.mode inside {ivalloc_pkg::MODE_ALLOC_ONE,
		ivalloc_pkg::MODE_ALLOC_BLOCK};
	assign fail_code = (stat.mode == ivalloc_pkg::MODE_ALLOC_ONE) ?
		ivalloc_pkg::RC_EXHAUSTED : ivalloc_pkg::RC_NO_SPACE;
	assign req_stall = (state_q != ivalloc_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ivalloc_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ivalloc_pkg::S_IDLE: begin
				if (req_valid) begin
					state_nxt = ivalloc_pkg::S_DISPATCH;
				end
			end
			ivalloc_pkg::S_DISPATCH: begin
				case (stat.mode)
					ivalloc_pkg::MODE_ALLOC_ONE: begin
						state_nxt = ivalloc_pkg::S_SCAN_RD;
					end
					ivalloc_pkg::MODE_ALLOC_BLOCK: begin
						state_nxt = stat.blk_ok ? ivalloc_pkg::S_SCAN_RD : ivalloc_pkg::S_PUSH;
					end
					ivalloc_pkg::MODE_FREE_RANGE, ivalloc_pkg::MODE_FREE_ONE: begin
						state_nxt = (stat.rng_ok && !stat.rng_empty) ?
							ivalloc_pkg::S_FILL : ivalloc_pkg::S_PUSH;
					end
					ivalloc_pkg::MODE_REGISTER, ivalloc_pkg::MODE_UNREGISTER: begin
						state_nxt = stat.vec_ok ? ivalloc_pkg::S_RMW_RD : ivalloc_pkg::S_PUSH;
					end
					default: begin
						state_nxt = ivalloc_pkg::S_PUSH;
					end
				endcase
			end
			ivalloc_pkg::S_SCAN_RD: begin
				state_nxt = stat.in_table ? ivalloc_pkg::S_SCAN_CHK : ivalloc_pkg::S_PUSH;
			end
			ivalloc_pkg::S_SCAN_CHK: begin
				if (stat.entry == ivalloc_pkg::VS_FREE && stat.block_last) begin
					state_nxt = ivalloc_pkg::S_FILL;
				end else begin
					state_nxt = ivalloc_pkg::S_SCAN_RD;
				end
			end
			ivalloc_pkg::S_FILL: begin
				if (stat.fill_last) begin
					state_nxt = ivalloc_pkg::S_PUSH;
				end
			end
			ivalloc_pkg::S_RMW_RD: begin
				state_nxt = ivalloc_pkg::S_RMW_CHK;
			end
			ivalloc_pkg::S_RMW_CHK: begin
				state_nxt = ivalloc_pkg::S_PUSH;
			end
			ivalloc_pkg::S_PUSH: begin
				if (stat.out_free) begin
					state_nxt = ivalloc_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = ivalloc_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ivalloc_pkg::S_IDLE: begin
				cmd.load = req_valid;
			end
			ivalloc_pkg::S_DISPATCH: begin
				cmd.res_status = ivalloc_pkg::RC_INVALID;
				case (stat.mode)
					ivalloc_pkg::MODE_ALLOC_ONE: begin
						cmd.scan_init = 1'b1;
					end
					ivalloc_pkg::MODE_ALLOC_BLOCK: begin
						cmd.scan_init = stat.blk_ok;
						cmd.result    = !stat.blk_ok;
					end
					ivalloc_pkg::MODE_FREE_RANGE, ivalloc_pkg::MODE_FREE_ONE: begin
						cmd.target_init = stat.rng_ok;
						// an empty range with a valid start reports ok without touching the store
						cmd.result      = !stat.rng_ok || stat.rng_empty;
						if (stat.rng_ok) begin
							cmd.res_status = ivalloc_pkg::RC_OK;
						end
					end
					ivalloc_pkg::MODE_REGISTER, ivalloc_pkg::MODE_UNREGISTER: begin
						cmd.target_init = stat.vec_ok;
						cmd.result      = !stat.vec_ok;
					end
					default: begin
						cmd.result = 1'b1;
					end
				endcase
			end
			ivalloc_pkg::S_SCAN_RD: begin
				cmd.read       = stat.in_table;
				cmd.result     = !stat.in_table;
				cmd.res_status = fail_code;
			end
			ivalloc_pkg::S_SCAN_CHK: begin
				if (stat.entry == ivalloc_pkg::VS_FREE) begin
					cmd.found = stat.block_last;
					cmd.step  = !stat.block_last;
				end else begin
					cmd.skip = 1'b1;
				end
			end
			ivalloc_pkg::S_FILL: begin
				cmd.write      = 1'b1;
				cmd.wdata      = is_alloc ? ivalloc_pkg::VS_ALLOC : ivalloc_pkg::VS_FREE;
				cmd.step       = 1'b1;
				cmd.result     = stat.fill_last;
				cmd.res_status = ivalloc_pkg::RC_OK;
				cmd.res_grant  = is_alloc;
			end
			ivalloc_pkg::S_RMW_RD: begin
				cmd.read = 1'b1;
			end
			ivalloc_pkg::S_RMW_CHK: begin
				cmd.result = 1'b1;
				if (stat.mode == ivalloc_pkg::MODE_REGISTER) begin
					if (stat.entry == ivalloc_pkg::VS_FREE) begin
						cmd.res_status = ivalloc_pkg::RC_NOT_ALLOC;
					end else if (stat.entry == ivalloc_pkg::VS_REG) begin
						cmd.res_status = ivalloc_pkg::RC_ALREADY;
					end else begin
						cmd.write      = 1'b1;
						cmd.wdata      = ivalloc_pkg::VS_REG;
						cmd.res_status = ivalloc_pkg::RC_OK;
					end
				end else begin
					if (stat.entry == ivalloc_pkg::VS_FREE) begin
						cmd.res_status = ivalloc_pkg::RC_NOTHING_REG;
					end else begin
						cmd.write      = 1'b1;
						cmd.wdata      = ivalloc_pkg::VS_ALLOC;
						cmd.res_status = ivalloc_pkg::RC_OK;
					end
				end
			end
			ivalloc_pkg::S_PUSH: begin
				cmd.push = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/interrupt_vector_allocator.sv =====
// Interrupt vector allocator: one request at a time, one result per request.
// A rejected request goes straight to the result; register/unregister reads the entry, then
// checks it and writes it when the change is allowed; free writes each entry of the range;
// allocation scans the table, reading and then checking each entry, and fills the block once
// a free aligned block is found, or fails when the scan runs past the table. A new request is taken once the
// previous result is in the output register. Reset clears the per-entry valid bits at once.
`default_nettype none
module interrupt_vector_allocator #(
	parameter int NUM_VECTORS   = 256,
	parameter int FIRST_DYNAMIC = 32,
	parameter int MAX_BLOCK     = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire ivalloc_pkg::req_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output ivalloc_pkg::rsp_t      rsp
);

	ivalloc_pkg::cmd_t  cmd;
	ivalloc_pkg::stat_t stat;

	ivalloc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	ivalloc_dp #(
		.NUM_VECTORS  (NUM_VECTORS),
		.FIRST_DYNAMIC(FIRST_DYNAMIC),
		.MAX_BLOCK    (MAX_BLOCK)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.stat     (stat),
		.rsp_stall(rsp_stall),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

endmodule
`default_nettype wire
